// ===== hdl/iir_tdf2_pkg.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_pkg
// Shared widths, coefficient map, accumulator codes and the command word
// passed from the sequencer to the arithmetic datapath.
// ----------------------------------------------------------------------------
package iir_tdf2_pkg;

  localparam int FILTER_ORDER = 3;

  localparam int COEF_W      = 18;
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = COEF_W + SAMPLE_W;
  localparam int DELAY_W     = 40;
  localparam int ACC_W       = DELAY_W + 2;
  localparam int MAG_W       = DELAY_W + 1;
  localparam int Q_W         = SAMPLE_W + 1;
  localparam int DVS_W       = COEF_W + Q_W - 1;
  localparam int CNT_W       = $clog2(Q_W);
  localparam int K_W         = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;

  localparam int NUM_COEF    = 8;
  localparam int COEF_IDX_W  = 3;
  localparam int COEF_A_BASE = 4;
  localparam int CFG_IDX_W   = 8;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(16384);

  typedef logic [1:0] acc_op_t;
  localparam acc_op_t ACC_HOLD  = 2'd0;
  localparam acc_op_t ACC_NUM   = 2'd1;
  localparam acc_op_t ACC_CARRY = 2'd2;
  localparam acc_op_t ACC_SUB   = 2'd3;

  typedef struct packed {
    logic                  load_x;
    logic                  mul_en;
    logic                  mul_y;
    logic [COEF_IDX_W-1:0] coef_idx;
    acc_op_t               acc_op;
    logic                  div_load;
    logic                  div_step;
    logic                  fin;
    logic                  out_load;
    logic [K_W-1:0]        dly_idx;
  } cmd_t;

  function automatic logic signed [COEF_W-1:0] coef_reset(input int idx);
    logic signed [COEF_W-1:0] v;
    v = '0;
    if (idx == 0 || idx == COEF_A_BASE) v = COEF_ONE;
    return v;
  endfunction

endpackage

// ===== hdl/iir_tdf2_ctrl.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_ctrl
// Sequencer: steps one sample through multiply, divide, output and the
// delay-line update, and owns the handshake state of both streams.
// ----------------------------------------------------------------------------
module iir_tdf2_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output iir_tdf2_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M0   = 4'd1;
  localparam logic [3:0] S_NUM  = 4'd2;
  localparam logic [3:0] S_DSET = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_OUT  = 4'd6;
  localparam logic [3:0] S_MB   = 4'd7;
  localparam logic [3:0] S_MA   = 4'd8;
  localparam logic [3:0] S_SUB  = 4'd9;

  logic [3:0]                         state_r, state_nxt;
  logic [iir_tdf2_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [iir_tdf2_pkg::K_W-1:0]       k_r, k_nxt;
  logic                               out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        cmd.load_x = in_tvalid;
        if (in_tvalid) state_nxt = S_M0;
      end
      S_M0: begin
        cmd.mul_en   = 1'b1;
        cmd.coef_idx = '0;
        state_nxt    = S_NUM;
      end
      S_NUM: begin
        cmd.acc_op = iir_tdf2_pkg::ACC_NUM;
        state_nxt  = S_DSET;
      end
      S_DSET: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = iir_tdf2_pkg::CNT_W'(iir_tdf2_pkg::Q_W - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_FIN;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          k_nxt        = '0;
          state_nxt    = S_MB;
        end
      end
      S_MB: begin
        cmd.mul_en   = 1'b1;
        cmd.coef_idx = iir_tdf2_pkg::COEF_IDX_W'(k_r) + 1'b1;
        state_nxt    = S_MA;
      end
      S_MA: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_y    = 1'b1;
        cmd.coef_idx = iir_tdf2_pkg::COEF_IDX_W'(iir_tdf2_pkg::COEF_A_BASE)
                       + iir_tdf2_pkg::COEF_IDX_W'(k_r) + 1'b1;
        cmd.acc_op   = iir_tdf2_pkg::ACC_CARRY;
        cmd.dly_idx  = k_r;
        state_nxt    = S_SUB;
      end
      S_SUB: begin
        cmd.acc_op  = iir_tdf2_pkg::ACC_SUB;
        cmd.dly_idx = k_r;
        if (k_r == iir_tdf2_pkg::K_W'(iir_tdf2_pkg::FILTER_ORDER - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_MB;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_M0))
    else $error("accepted word did not start the sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("pending output word overwritten");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> (state_r == S_FIN))
    else $error("divider did not hand over after last step");

  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_x, cmd.div_load, cmd.div_step, cmd.fin, cmd.out_load}))
    else $error("overlapping datapath phases");

endmodule

// ===== hdl/iir_tdf2_dp.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_dp
// Datapath: coefficient bank, shared 18x16 multiplier, accumulator,
// restoring divider for the a0 normalisation, delay line and output word.
// ----------------------------------------------------------------------------
module iir_tdf2_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  iir_tdf2_pkg::cmd_t                       cmd,
  input  logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                     cfg_we,
  input  logic [iir_tdf2_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [iir_tdf2_pkg::COEF_W-1:0]          cfg_data,
  output logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                     out_sat
);

  localparam int SW = iir_tdf2_pkg::SAMPLE_W;
  localparam int CW = iir_tdf2_pkg::COEF_W;
  localparam int PW = iir_tdf2_pkg::PROD_W;
  localparam int DW = iir_tdf2_pkg::DELAY_W;
  localparam int AW = iir_tdf2_pkg::ACC_W;
  localparam int MW = iir_tdf2_pkg::MAG_W;
  localparam int QW = iir_tdf2_pkg::Q_W;
  localparam int VW = iir_tdf2_pkg::DVS_W;
  localparam int KW = iir_tdf2_pkg::K_W;
  localparam int NO = iir_tdf2_pkg::FILTER_ORDER;

  localparam logic signed [SW-1:0] Y_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] Y_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [QW-1:0] Q_POS_LIM = QW'(Y_MAX);
  localparam logic [QW-1:0] Q_NEG_LIM = {2'b01, {(QW-2){1'b0}}};
  localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [CW-1:0] coef_r [iir_tdf2_pkg::NUM_COEF];
  logic signed [DW-1:0] z_r [NO];
  logic signed [SW-1:0] x_r, y_r, y_nxt;
  logic signed [PW-1:0] p_r, prod;
  logic signed [AW-1:0] acc_r, diff;
  logic signed [DW-1:0] carry, z_new;
  logic [KW-1:0]        nxt_idx;
  logic signed [CW-1:0] mul_a, a0;
  logic signed [SW-1:0] mul_b;
  logic [CW-1:0]        a0_mag;
  logic [MW-1:0]        num_mag, rem_r;
  logic [VW-1:0]        dvs_r;
  logic [QW-1:0]        q_r;
  logic                 zero_r, ovf_r, neg_r, num_neg_r, sat_r, sat_nxt;

  assign a0     = coef_r[iir_tdf2_pkg::COEF_A_BASE];
  assign a0_mag = a0[CW-1] ? CW'(-a0) : CW'(a0);
  assign num_mag = acc_r[AW-1] ? MW'(-acc_r) : MW'(acc_r);

  assign mul_a = coef_r[cmd.coef_idx];
  assign mul_b = cmd.mul_y ? y_r : x_r;
  assign prod  = PW'(mul_a) * PW'(mul_b);

  assign nxt_idx = cmd.dly_idx + 1'b1;
  always_comb begin
    carry = '0;
    if (int'(cmd.dly_idx) + 1 < NO) carry = z_r[nxt_idx];
  end

  assign diff = acc_r - AW'(p_r);
  always_comb begin
    if (diff > AW'(D_MAX)) z_new = D_MAX;
    else if (diff < AW'(D_MIN)) z_new = D_MIN;
    else z_new = DW'(diff);
  end

  always_comb begin
    sat_nxt = 1'b1;
    y_nxt   = neg_r ? Y_MIN : Y_MAX;
    if (zero_r) begin
      y_nxt = num_neg_r ? Y_MIN : Y_MAX;
    end else if (!ovf_r && !neg_r && q_r <= Q_POS_LIM) begin
      sat_nxt = 1'b0;
      y_nxt   = SW'(q_r);
    end else if (!ovf_r && neg_r && q_r <= Q_NEG_LIM) begin
      sat_nxt = 1'b0;
      y_nxt   = SW'(-q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < iir_tdf2_pkg::NUM_COEF; i++) begin
        coef_r[i] <= iir_tdf2_pkg::coef_reset(i);
      end
      for (int i = 0; i < NO; i++) begin
        z_r[i] <= '0;
      end
    end else begin
      if (cfg_we && cfg_index < iir_tdf2_pkg::CFG_IDX_W'(iir_tdf2_pkg::NUM_COEF)) begin
        coef_r[cfg_index[iir_tdf2_pkg::COEF_IDX_W-1:0]] <= cfg_data;
      end
      if (cmd.acc_op == iir_tdf2_pkg::ACC_SUB) z_r[cmd.dly_idx] <= z_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) x_r <= in_sample;
    if (cmd.mul_en) p_r <= prod;
    case (cmd.acc_op)
      iir_tdf2_pkg::ACC_NUM:   acc_r <= AW'(p_r) + AW'(z_r[0]);
      iir_tdf2_pkg::ACC_CARRY: acc_r <= AW'(p_r) + AW'(carry);
      default: ;
    endcase
    if (cmd.div_load) begin
      rem_r     <= num_mag;
      dvs_r     <= {a0_mag, {(QW-1){1'b0}}};
      q_r       <= '0;
      zero_r    <= (a0 == '0);
      ovf_r     <= (num_mag >= MW'({a0_mag, {QW{1'b0}}}));
      num_neg_r <= acc_r[AW-1];
      neg_r     <= acc_r[AW-1] ^ a0[CW-1];
    end else if (cmd.div_step) begin
      if (rem_r >= MW'(dvs_r)) begin
        rem_r <= rem_r - MW'(dvs_r);
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.fin) begin
      y_r   <= y_nxt;
      sat_r <= sat_nxt;
    end
    if (cmd.out_load) begin
      out_sample <= y_r;
      out_sat    <= sat_r;
    end
  end

endmodule

// ===== hdl/iir_filter_transposed_df2_top.sv =====
// ----------------------------------------------------------------------------
// iir_filter_transposed_df2_top
// Third-order transposed direct form II IIR filter, Q4.14 coefficients,
// Q1.15 samples, 40-bit delays, saturating output with clip flag.
//
//   channel  direction  handshake           payload
//   in_      slave      in_tvalid/tready    tdata[15:0] sample_in
//   out_     master     out_tvalid/tready   tdata[15:0] sample_out,
//                                           tuser[0] saturated
//   cfg_     slave      cfg_valid/ready     cfg_index[7:0], cfg_data[17:0]
//
// A new sample is taken only once the previous one has finished its delay-line
// update: the 17-step restoring divider and the single shared multiplier,
// used in turn for each delay tap, set the pace.
// Reset (rst_n low, synchronous) loads b0 = a0 = 1.0, others 0, delays 0.
// A result waits in the output register; a stall only holds the sequence
// once the next result is ready to be written there.
// ----------------------------------------------------------------------------
module iir_filter_transposed_df2_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [iir_tdf2_pkg::SAMPLE_W-1:0]      in_tdata,   // sample_in
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [iir_tdf2_pkg::SAMPLE_W-1:0]      out_tdata,  // sample_out
  output logic [0:0]                             out_tuser,  // saturated
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [iir_tdf2_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iir_tdf2_pkg::COEF_W-1:0]        cfg_data
);

  iir_tdf2_pkg::cmd_t                       cmd;
  logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] out_sample;
  logic                                     out_sat;

  assign cfg_ready    = 1'b1;
  assign out_tdata    = out_sample;
  assign out_tuser[0] = out_sat;

  iir_tdf2_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  iir_tdf2_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_sample  (in_tdata),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_sample (out_sample),
    .out_sat    (out_sat)
  );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the third-order transposed direct form II IIR
// filter. A predictor tracks the coefficients and the 40-bit delays, works
// out each output word and its clip flag, and checks the output stream in
// order. A directed opening covers identity, clipping, truncation, a zero
// divisor, ignored register indexes and an FIR set. Random phases follow,
// each with a fresh coefficient set and its own idle and stall pattern.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SAMPLE_W    = iir_tdf2_pkg::SAMPLE_W;
  localparam int COEF_W      = iir_tdf2_pkg::COEF_W;
  localparam int CFG_IDX_W   = iir_tdf2_pkg::CFG_IDX_W;
  localparam int NUM_COEF    = iir_tdf2_pkg::NUM_COEF;
  localparam int COEF_A_BASE = iir_tdf2_pkg::COEF_A_BASE;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                sat;
  } filt_word_t;

  typedef enum {
    STYLE_WILD,
    STYLE_FIR,
    STYLE_GENTLE,
    STYLE_CORNER,
    STYLE_TINY_DIV
  } coef_style_t;

  localparam int     ORDER         = iir_tdf2_pkg::FILTER_ORDER;
  localparam int     IDX_BEYOND    = NUM_COEF;
  localparam int     IDX_TOP       = 2 ** CFG_IDX_W - 1;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     RANDOM_PHASES = 13;
  localparam int     PHASE_WORDS   = 100;
  localparam longint SAMPLE_MAX    = 32767;
  localparam longint SAMPLE_MIN    = -32768;
  localparam longint DLY_MAX       = (64'sd1 <<< (iir_tdf2_pkg::DELAY_W - 1)) - 1;
  localparam longint DLY_MIN       = -(64'sd1 <<< (iir_tdf2_pkg::DELAY_W - 1));

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [SAMPLE_W-1:0]  in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [SAMPLE_W-1:0]  out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [COEF_W-1:0]    cfg_data   = '0;

  longint coef_b [0:COEF_A_BASE-1];
  longint coef_a [0:COEF_A_BASE-1];
  longint dly    [0:ORDER-1];

  logic [SAMPLE_W-1:0] sample_backlog [$];
  filt_word_t          expected_words [$];

  int     words_taken;
  int     words_sent;
  int     sender_idle_pct;
  int     receiver_stall_pct;
  int     hold_req;
  int     hold_ack;
  int     hold_left;
  int     mismatches;
  logic   offering;

  iir_filter_transposed_df2_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void filter_sample(input logic [SAMPLE_W-1:0] x_bits,
                                        output filt_word_t res);
    longint x;
    longint num;
    longint y;
    longint acc;
    longint carry;
    logic   clip;
    x    = longint'($signed(x_bits));
    num  = coef_b[0] * x + dly[0];
    clip = 1'b0;
    if (coef_a[0] == 0) begin
      y    = (num >= 0) ? SAMPLE_MAX : SAMPLE_MIN;
      clip = 1'b1;
    end else begin
      y = num / coef_a[0];
      if (y > SAMPLE_MAX) begin
        y    = SAMPLE_MAX;
        clip = 1'b1;
      end else if (y < SAMPLE_MIN) begin
        y    = SAMPLE_MIN;
        clip = 1'b1;
      end
    end
    for (int k = 0; k < ORDER; k++) begin
      carry = (k + 1 < ORDER) ? dly[k + 1] : 64'sd0;
      acc   = coef_b[k + 1] * x + carry - coef_a[k + 1] * y;
      if (acc > DLY_MAX) acc = DLY_MAX;
      if (acc < DLY_MIN) acc = DLY_MIN;
      dly[k] = acc;
    end
    res.sample = y[SAMPLE_W-1:0];
    res.sat    = clip;
  endfunction

  function automatic int coef_draw(coef_style_t style, int idx);
    int picks [6];
    int v;
    picks = '{-131072, 131071, 0, -1, 1, 16384};
    case (style)
      STYLE_WILD:     v = int'($urandom_range(0, 262143)) - 131072;
      STYLE_FIR: begin
        if (idx == COEF_A_BASE) v = 16384;
        else if (idx > COEF_A_BASE) v = 0;
        else v = int'($urandom_range(0, 65535)) - 32768;
      end
      STYLE_GENTLE: begin
        if (idx == COEF_A_BASE) v = int'($urandom_range(8192, 32768));
        else if (idx > COEF_A_BASE) v = int'($urandom_range(0, 8192)) - 4096;
        else v = int'($urandom_range(0, 16384)) - 8192;
      end
      STYLE_CORNER:   v = picks[$urandom_range(0, 5)];
      default: begin
        if (idx == COEF_A_BASE) v = int'($urandom_range(0, 16)) - 8;
        else v = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = 16'h7fff;
      1:       s = 16'h8000;
      2:       s = SAMPLE_W'(int'($urandom_range(0, 63)) - 32);
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  task automatic write_coef(input int idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= COEF_W'(val);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_coefs(input int vals [0:NUM_COEF-1]);
    for (int i = 0; i < NUM_COEF; i++) write_coef(i, vals[i]);
  endtask

  task automatic settle();
    do @(posedge clk); while (sample_backlog.size() != 0 || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_words(input int vals [$]);
    foreach (vals[i]) sample_backlog.push_back(SAMPLE_W'(vals[i]));
  endtask

  task automatic queue_random(input int n);
    repeat (n) sample_backlog.push_back(random_sample());
  endtask

  // drive the input stream; hold a word until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offering = in_tvalid;
      if (words_taken != words_sent) begin
        void'(sample_backlog.pop_front());
        words_sent++;
        offering = 1'b0;
      end
      if (!offering && sample_backlog.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) offering = 1'b1;
      in_tvalid <= offering;
      if (offering) in_tdata <= sample_backlog[0];
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack   = hold_req;
      hold_left  = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    filt_word_t fresh;
    filt_word_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < COEF_A_BASE)
          coef_b[cfg_index] = longint'($signed(cfg_data));
        else if (cfg_index < NUM_COEF)
          coef_a[cfg_index - COEF_A_BASE] = longint'($signed(cfg_data));
      end
      if (in_tvalid && in_tready) begin
        filter_sample(in_tdata, fresh);
        expected_words.push_back(fresh);
        words_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, actual sample_out %h saturated %b",
                   $time, out_tdata, out_tuser[0]);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_tdata !== want.sample) begin
            $display("%0t: sample_out expected %h actual %h",
                     $time, want.sample, out_tdata);
            mismatches++;
          end
          if (out_tuser[0] !== want.sat) begin
            $display("%0t: saturated expected %b actual %b",
                     $time, want.sat, out_tuser[0]);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    #(8 * 1000000);
    $display("FAIL");
    $finish;
  end

  initial begin
    int          dir_x [$];
    int          vals [0:NUM_COEF-1];
    coef_style_t style;
    words_taken        = 0;
    words_sent         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_req           = 0;
    hold_ack           = 0;
    hold_left          = 0;
    mismatches         = 0;
    foreach (coef_b[i]) begin
      coef_b[i] = 0;
      coef_a[i] = 0;
    end
    coef_b[0] = iir_tdf2_pkg::COEF_ONE;
    coef_a[0] = iir_tdf2_pkg::COEF_ONE;
    foreach (dly[i]) dly[i] = 0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset coefficients pass samples through unchanged
    dir_x = '{0, 32767, -32768, -1, 1, 12345};
    queue_words(dir_x);
    settle();

    // clipping both ways, truncation toward zero, indexes beyond the map
    load_coefs('{-131072, 131071, -1, 1, 3, -131072, 131071, -1});
    write_coef(IDX_BEYOND, 0);
    write_coef(IDX_TOP, 131071);
    dir_x = '{1, -1, 32767, -32768, 0};
    queue_words(dir_x);
    settle();

    // zero divisor, including a zero numerator
    load_coefs('{16384, 0, 0, 0, 0, 0, 0, 0});
    dir_x = '{7, 0, -7, 32767, -32768};
    queue_words(dir_x);
    settle();

    // FIR set
    load_coefs('{8192, -16384, 4096, 131071, 16384, 0, 0, 0});
    dir_x = '{32767, -32768, 100, 0, 0};
    queue_words(dir_x);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      style = coef_style_t'($urandom_range(0, 4));
      if (p == 1) style = STYLE_CORNER;
      for (int i = 0; i < NUM_COEF; i++) vals[i] = coef_draw(style, i);
      if (p == 2) vals = '{-131072, -131072, -131072, -131072,
                           -131072, -131072, -131072, -131072};
      if (p == 4) vals = '{131071, 131071, 131071, 131071,
                           131071, 131071, 131071, 131071};
      load_coefs(vals);
      if ($urandom_range(0, 3) == 0)
        write_coef($urandom_range(IDX_BEYOND, IDX_TOP), int'($urandom_range(0, 262143)));

      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
        default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
      endcase

      if (p == 3) hold_req++;
      if (p == 6) begin
        queue_random(PHASE_WORDS / 2);
        settle();
        queue_random(PHASE_WORDS - PHASE_WORDS / 2);
      end else begin
        queue_random(PHASE_WORDS);
      end
      settle();
    end

    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/iir_tdf2_pkg.sv
hdl/iir_tdf2_ctrl.sv
hdl/iir_tdf2_dp.sv
hdl/iir_filter_transposed_df2_top.sv
test/testbench.sv
